// ===== design/slr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the regression unit.
`timescale 1ns / 1ps
`default_nettype none
package slr_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int CNT_W       = 17;
    localparam int ACC_W       = 84;
    localparam int DVD_W       = 96;
    localparam int DIV_STEPS   = 96;
    localparam int STEP_W      = 7;

    localparam logic [47:0] SAT_POS = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] SAT_NEG = 48'h8000_0000_0000;
    localparam logic [49:0] Q_CAP   = 50'h1_0000_0000_0000;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_ZVAR = 2'd2;

    // product schedule: den terms, slope numerator terms, intercept numerator terms
    localparam logic [2:0] P_N_SXX  = 3'd0;
    localparam logic [2:0] P_SX_SX  = 3'd1;
    localparam logic [2:0] P_N_SXY  = 3'd2;
    localparam logic [2:0] P_SX_SY  = 3'd3;
    localparam logic [2:0] P_SY_SXX = 3'd4;
    localparam logic [2:0] P_SX_SXY = 3'd5;

    typedef struct packed {
        logic       accept;
        logic       init_res;
        logic       set_zero_var;
        logic       mul_en;
        logic [2:0] prod;
        logic [1:0] digit;
        logic       den_load;
        logic       div_load;
        logic       div_shift16;
        logic       div_step;
        logic       store_slope;
        logic       store_icpt;
        logic       clear_sums;
    } t_cmd;

    typedef struct packed {
        logic lt2;
        logic den_zero;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/simple_linear_regression_unit.sv =====
// Least-squares line fit: a pair is taken on each request while accumulating (busy stays low).
// After a request marked last, busy stays high until the result is taken; it comes straight
// after the check when fewer than two pairs, and after the denominator on zero variance of x.
// The time goes to a 48x16 multiply-accumulate (a 16-bit digit a step) and a one-bit-per-cycle
// divider run 96 steps for each of slope and intercept. Results cannot be stalled.
// Reset (i_rst_n low, synchronous) clears the controller and all sums.
`timescale 1ns / 1ps
`default_nettype none
module simple_linear_regression_unit import slr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic signed [15:0] i_x_value,
    input  wire logic signed [15:0] i_y_value,
    input  wire logic               i_last,
    output logic                    busy,
    output logic                    o_valid,
    output logic signed [47:0]      o_intercept,
    output logic signed [47:0]      o_slope,
    output logic [1:0]              o_status
);

    t_cmd  w_cmd;
    t_stat w_stat;

    slr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_last),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    slr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_x_value   (i_x_value),
        .i_y_value   (i_y_value),
        .o_stat      (w_stat),
        .o_intercept (o_intercept),
        .o_slope     (o_slope),
        .o_status    (o_status)
    );

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy) else $error("busy after result strobe");
    a_stream_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_last) |=> !busy) else $error("busy after non-last request");
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_last) |=> (busy && !o_valid)) else $error("last request not held");
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_FEW || o_status == ST_ZVAR))
        else $error("bad status code");
`endif

endmodule
`default_nettype wire

// ===== design/slr_datapath.sv =====
// Datapath: sample sums, shared digit multiplier-accumulator and restoring divider.
`timescale 1ns / 1ps
`default_nettype none
module slr_datapath import slr_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    input  wire logic signed [15:0] i_x_value,
    input  wire logic signed [15:0] i_y_value,
    output t_stat                   o_stat,
    output logic signed [47:0]      o_intercept,
    output logic signed [47:0]      o_slope,
    output logic [1:0]              o_status
);

    logic [CNT_W-1:0]   r_count;
    logic signed [32:0] r_sum_x;
    logic signed [32:0] r_sum_y;
    logic [46:0]        r_sum_xx;
    logic signed [47:0] r_sum_xy;

    logic [ACC_W-1:0] r_acc;
    logic [63:0]      r_den;
    logic [DVD_W-1:0] r_dvd;
    logic [64:0]      r_rem;
    logic [49:0]      r_quo;
    logic             r_neg;
    logic [47:0]      r_icpt;
    logic [47:0]      r_slope;
    logic [1:0]       r_status;

    logic signed [31:0] w_xx;
    logic signed [31:0] w_xy;
    logic [47:0]        w_n_mag;
    logic [47:0]        w_sx_mag;
    logic [47:0]        w_sy_mag;
    logic [47:0]        w_sxy_mag;
    logic [47:0]        w_a_mag;
    logic [47:0]        w_b_mag;
    logic               w_a_neg;
    logic               w_b_neg;
    logic [15:0]        w_digit;
    logic [63:0]        w_pp;
    logic [ACC_W-1:0]   w_term;
    logic               w_term_neg;
    logic [ACC_W-1:0]   w_acc_mag;
    logic [64:0]        w_rs;
    logic               w_ge;
    logic [49:0]        w_qn;
    logic [64:0]        w_half;
    logic [49:0]        w_qr;
    logic [47:0]        w_res;

    assign w_xx = i_x_value * i_x_value;
    assign w_xy = i_x_value * i_y_value;

    assign w_n_mag   = 48'(r_count);
    assign w_sx_mag  = 48'(r_sum_x[32] ? 33'(-r_sum_x) : 33'(r_sum_x));
    assign w_sy_mag  = 48'(r_sum_y[32] ? 33'(-r_sum_y) : 33'(r_sum_y));
    assign w_sxy_mag = r_sum_xy[47] ? 48'(-r_sum_xy) : 48'(r_sum_xy);

    always_comb begin
        w_a_mag = '0;
        w_b_mag = '0;
        w_a_neg = 1'b0;
        w_b_neg = 1'b0;
        case (i_cmd.prod)
            P_N_SXX: begin
                w_a_mag = w_n_mag;
                w_b_mag = 48'(r_sum_xx);
            end
            P_SX_SX: begin
                w_a_mag = w_sx_mag;
                w_b_mag = w_sx_mag;
                w_a_neg = r_sum_x[32];
                w_b_neg = r_sum_x[32];
            end
            P_N_SXY: begin
                w_a_mag = w_n_mag;
                w_b_mag = w_sxy_mag;
                w_b_neg = r_sum_xy[47];
            end
            P_SX_SY: begin
                w_a_mag = w_sx_mag;
                w_b_mag = w_sy_mag;
                w_a_neg = r_sum_x[32];
                w_b_neg = r_sum_y[32];
            end
            P_SY_SXX: begin
                w_a_mag = w_sy_mag;
                w_b_mag = 48'(r_sum_xx);
                w_a_neg = r_sum_y[32];
            end
            P_SX_SXY: begin
                w_a_mag = w_sx_mag;
                w_b_mag = w_sxy_mag;
                w_a_neg = r_sum_x[32];
                w_b_neg = r_sum_xy[47];
            end
            default: begin
                w_a_mag = '0;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.digit)
            2'd0:    w_digit = w_b_mag[15:0];
            2'd1:    w_digit = w_b_mag[31:16];
            2'd2:    w_digit = w_b_mag[47:32];
            default: w_digit = '0;
        endcase
    end

    assign w_pp       = w_a_mag * w_digit;
    assign w_term     = ACC_W'(w_pp) << (6'(i_cmd.digit) << 4);
    // odd products are the subtracted terms
    assign w_term_neg = w_a_neg ^ w_b_neg ^ i_cmd.prod[0];
    assign w_acc_mag  = r_acc[ACC_W-1] ? -r_acc : r_acc;

    assign w_rs   = {r_rem[63:0], r_dvd[DVD_W-1]};
    assign w_ge   = w_rs >= {1'b0, r_den};
    assign w_qn   = {r_quo[48:0], w_ge};
    assign w_half = {1'b0, r_den} - r_rem;
    assign w_qr   = r_quo + 50'(r_rem >= w_half);

    always_comb begin
        if (w_qr > 50'(SAT_POS)) begin
            w_res = r_neg ? SAT_NEG : SAT_POS;
        end else begin
            w_res = r_neg ? -w_qr[47:0] : w_qr[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_sums) begin
            r_count  <= '0;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_sum_xx <= '0;
            r_sum_xy <= '0;
        end else if (i_cmd.accept && (r_count < CNT_W'(MAX_SAMPLES))) begin
            r_count  <= r_count + 1'b1;
            r_sum_x  <= r_sum_x + 33'(i_x_value);
            r_sum_y  <= r_sum_y + 33'(i_y_value);
            r_sum_xx <= r_sum_xx + 47'($unsigned(w_xx));
            r_sum_xy <= r_sum_xy + 48'(w_xy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init_res || i_cmd.den_load || i_cmd.store_slope || i_cmd.store_icpt) begin
            r_acc <= '0;
        end else if (i_cmd.mul_en) begin
            r_acc <= w_term_neg ? (r_acc - w_term) : (r_acc + w_term);
        end
        if (i_cmd.den_load) begin
            r_den <= r_acc[63:0];
        end
        if (i_cmd.div_load) begin
            r_dvd <= i_cmd.div_shift16 ? (DVD_W'(w_acc_mag) << 16) : (DVD_W'(w_acc_mag) << 8);
            r_neg <= r_acc[ACC_W-1];
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_rem <= w_ge ? (w_rs - {1'b0, r_den}) : w_rs;
            r_quo <= (w_qn > Q_CAP) ? Q_CAP : w_qn;
        end
        if (i_cmd.init_res) begin
            r_icpt   <= '0;
            r_slope  <= '0;
            r_status <= (r_count < CNT_W'(2)) ? ST_FEW : ST_OK;
        end else if (i_cmd.set_zero_var) begin
            r_status <= ST_ZVAR;
        end
        if (i_cmd.store_slope) begin
            r_slope <= w_res;
        end
        if (i_cmd.store_icpt) begin
            r_icpt <= w_res;
        end
    end

    assign o_stat.lt2      = r_count < CNT_W'(2);
    assign o_stat.den_zero = r_acc == '0;
    assign o_intercept     = r_icpt;
    assign o_slope         = r_slope;
    assign o_status        = r_status;

endmodule
`default_nettype wire

// ===== design/slr_ctrl.sv =====
// Controller: sequences accumulation, products, divisions and the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module slr_ctrl import slr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    input  wire logic  i_last,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       busy,
    output logic       o_valid
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_MUL   = 8'b0000_0100,
        S_DEN   = 8'b0000_1000,
        S_LOAD  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_ROUND = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_prod, n_prod;
    logic [1:0]        r_digit, n_digit;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_prod  = r_prod;
        n_digit = r_digit;
        n_step  = r_step;
        o_cmd   = '0;
        o_cmd.prod  = r_prod;
        o_cmd.digit = r_digit;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_last) begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.init_res = 1'b1;
                n_prod  = P_N_SXX;
                n_digit = 2'd0;
                n_state = i_stat.lt2 ? S_DONE : S_MUL;
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                if (r_digit == 2'd2) begin
                    n_digit = 2'd0;
                    n_prod  = r_prod + 3'd1;
                    if (r_prod == P_SX_SX) begin
                        n_state = S_DEN;
                    end else if (r_prod[0]) begin
                        n_state = S_LOAD;
                    end
                end else begin
                    n_digit = r_digit + 2'd1;
                end
            end
            S_DEN: begin
                o_cmd.den_load = 1'b1;
                if (i_stat.den_zero) begin
                    o_cmd.set_zero_var = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_LOAD: begin
                o_cmd.div_load    = 1'b1;
                o_cmd.div_shift16 = (r_prod == P_SY_SXX);
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_state = S_ROUND;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_ROUND: begin
                // slope first, then the intercept numerator
                if (r_prod == P_SY_SXX) begin
                    o_cmd.store_slope = 1'b1;
                    n_state = S_MUL;
                end else begin
                    o_cmd.store_icpt = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.clear_sums = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_prod  <= '0;
            r_digit <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_prod  <= n_prod;
            r_digit <= n_digit;
            r_step  <= n_step;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule
`default_nettype wire
